// ----- sv/tpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the two-level priority queue.
// No dependencies.
package tpq_pkg;

    localparam int unsigned DEFAULT_DEPTH      = 8;
    localparam int unsigned DEFAULT_DATA_WIDTH = 32;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] KEY_HIGH = 2'd1;
    localparam logic [1:0] KEY_LOW  = 2'd2;
    localparam logic [1:0] LVL_NONE = 2'd0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

endpackage

// ----- sv/tpq_fifo_mem.sv -----
`timescale 1ns / 1ps
// One queue level: circular buffer memory with head/tail pointers and fill count.
// Depends on tpq_pkg. Read data is registered, valid in the cycle after pop.
module tpq_fifo_mem #(
    parameter int unsigned DEPTH      = tpq_pkg::DEFAULT_DEPTH,
    parameter int unsigned DATA_WIDTH = tpq_pkg::DEFAULT_DATA_WIDTH,
    parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tpq_pkg::t_fifo_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata,
    output logic [CW-1:0]         o_count
);
    import tpq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
            n_count = r_count + CW'(1);
        end else if (i_ctrl.pop) begin
            n_head  = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_ctrl.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

// ----- sv/two_level_priority_queue_top.sv -----
`timescale 1ns / 1ps
// Two-level strict priority queue: control FSM, output register, two level memories.
// Depends on tpq_pkg and tpq_fifo_mem.
//
//  channel | valid       | stall       | fields
//  in      | i_in_valid  | o_in_stall  | i_op, i_item_value, i_priority_key
//  out     | o_out_valid | i_out_stall | o_status, o_removed_value, o_removed_level,
//          |             |             | o_high_count, o_low_count
//
// Insert, failed remove: result in the next cycle, one item per cycle unless output stalls.
// Successful remove: value passes the memory read register, then the output register.
// Reset clears pointers, fill counts and the FSM; memory contents are not cleared.
// Input stalls while a result waits under output stall and during the memory read cycle.
module two_level_priority_queue_top #(
    parameter int unsigned DEPTH      = tpq_pkg::DEFAULT_DEPTH,
    parameter int unsigned DATA_WIDTH = tpq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic signed [tpq_pkg::VALUE_W-1:0] i_item_value,
    input  logic [1:0]                  i_priority_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic signed [tpq_pkg::VALUE_W-1:0] o_removed_value,
    output logic [1:0]                  o_removed_level,
    output logic [tpq_pkg::COUNT_W-1:0] o_high_count,
    output logic [tpq_pkg::COUNT_W-1:0] o_low_count
);
    import tpq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [1:0]          r_level, n_level;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [CW-1:0]       r_hc, n_hc;
    logic [CW-1:0]       r_lc, n_lc;
    logic                r_pop_high, n_pop_high;

    t_fifo_ctrl            w_hi_ctrl, w_lo_ctrl;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_hi_rdata, w_lo_rdata;
    logic [CW-1:0]         w_hi_count, w_lo_count;
    logic                  w_accept;
    logic                  w_hi_full, w_lo_full;

    assign w_wdata   = DATA_WIDTH'(unsigned'(i_item_value));
    assign w_hi_full = (w_hi_count == FULL_CNT);
    assign w_lo_full = (w_lo_count == FULL_CNT);

    tpq_fifo_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .CW(CW)) u_high (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_hi_ctrl),
        .i_wdata (w_wdata),
        .o_rdata (w_hi_rdata),
        .o_count (w_hi_count)
    );

    tpq_fifo_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .CW(CW)) u_low (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_lo_ctrl),
        .i_wdata (w_wdata),
        .o_rdata (w_lo_rdata),
        .o_count (w_lo_count)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_level     = r_level;
        n_value     = r_value;
        n_hc        = r_hc;
        n_lc        = r_lc;
        n_pop_high  = r_pop_high;
        w_hi_ctrl   = '0;
        w_lo_ctrl   = '0;
        o_in_stall  = 1'b1;
        w_accept    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = r_out_valid && i_out_stall;
                w_accept   = i_in_valid && !o_in_stall;
                if (w_accept) begin
                    n_status = ST_OK;
                    n_level  = LVL_NONE;
                    n_value  = '0;
                    n_hc     = w_hi_count;
                    n_lc     = w_lo_count;
                    n_out_valid = 1'b1;
                    if (i_op == OP_INSERT) begin
                        priority if (w_hi_full && w_lo_full) begin
                            n_status = ST_FULL;
                        end else if (i_priority_key == KEY_HIGH) begin
                            if (w_hi_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_hi_ctrl.push = 1'b1;
                                n_hc = w_hi_count + CW'(1);
                            end
                        end else if (i_priority_key == KEY_LOW) begin
                            if (w_lo_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_lo_ctrl.push = 1'b1;
                                n_lc = w_lo_count + CW'(1);
                            end
                        end else begin
                            n_status = ST_INVALID;
                        end
                    end else begin
                        priority if (w_hi_count == '0 && w_lo_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (w_hi_count != '0) begin
                            w_hi_ctrl.pop = 1'b1;
                            n_hc        = w_hi_count - CW'(1);
                            n_level     = KEY_HIGH;
                            n_pop_high  = 1'b1;
                            n_out_valid = 1'b0;
                            n_state     = S_READ;
                        end else begin
                            w_lo_ctrl.pop = 1'b1;
                            n_lc        = w_lo_count - CW'(1);
                            n_level     = KEY_LOW;
                            n_pop_high  = 1'b0;
                            n_out_valid = 1'b0;
                            n_state     = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_value     = VALUE_W'(r_pop_high ? w_hi_rdata : w_lo_rdata);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_level    <= n_level;
        r_value    <= n_value;
        r_hc       <= n_hc;
        r_lc       <= n_lc;
        r_pop_high <= n_pop_high;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = signed'(r_value);
    assign o_removed_level = r_level;
    assign o_high_count    = COUNT_W'(r_hc);
    assign o_low_count     = COUNT_W'(r_lc);

    a_read_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("result pending during memory read");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hi_count <= FULL_CNT && w_lo_count <= FULL_CNT)
        else $error("level fill beyond depth");

    a_level_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_level != LVL_NONE |-> r_status == ST_OK)
        else $error("removed level on failed step");

    a_remove_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_op == OP_REMOVE && (w_hi_count != '0 || w_lo_count != '0)
        |=> r_state == S_READ)
        else $error("successful remove skipped memory read");

endmodule
